### design/cdo_pkg.sv
// cdo_pkg: shared types, constants and codes for the calendar date offset block
// no dependencies; compiled first
`default_nettype none

package cdo_pkg;

    // field widths
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int CNT_W   = 16;
    localparam int ACC_W   = CNT_W + 2;     // signed day accumulator
    localparam int YLIM_W  = 17;            // holds the year limit
    localparam int MLEN_W  = 5;

    // configuration of the block
    localparam int DAY_COUNT_BITS = 16;
    localparam int YEAR_LIMIT     = 9999;
    localparam logic [CNT_W-1:0] CNT_MASK =
        CNT_W'((64'd1 << DAY_COUNT_BITS) - 64'd1);
    localparam logic [YLIM_W-1:0] YEAR_MAX = YLIM_W'(YEAR_LIMIT);

    // calendar constants
    localparam logic [6:0] YEARS_PER_CENTURY = 7'd100;
    localparam logic [6:0] LAST_YEAR_OF_CENTURY = 7'd99;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_MONTH = 2'd1,
        STATUS_RANGE     = 2'd2
    } cdo_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_WALK,
        ST_DONE
    } cdo_state_t;

    typedef struct packed {
        logic               req_type;
        logic [YEAR_W-1:0]  in_year;
        logic [MONTH_W-1:0] in_month;
        logic [DAY_W-1:0]   in_day;
        logic [CNT_W-1:0]   day_count;
    } cdo_req_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  out_year;
        logic [MONTH_W-1:0] out_month;
        logic [DAY_W-1:0]   out_day;
        cdo_status_t        status;
    } cdo_rsp_t;

endpackage

`default_nettype wire

### design/cdo_if.sv
// cdo_if: valid/ready channel interfaces for requests and results
// depends on cdo_pkg
`default_nettype none

interface cdo_req_if;
    logic              valid;
    logic              ready;
    cdo_pkg::cdo_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cdo_rsp_if;
    logic              valid;
    logic              ready;
    cdo_pkg::cdo_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/cdo_alu.sv
// cdo_alu: shared signed add/subtract unit of the date sequencer
// depends on cdo_pkg
`default_nettype none

module cdo_alu (
    input  logic signed [cdo_pkg::ACC_W-1:0] a,
    input  logic signed [cdo_pkg::ACC_W-1:0] b,
    input  logic                             sub,
    output logic signed [cdo_pkg::ACC_W-1:0] res
);

    assign res = sub ? (a - b) : (a + b);

endmodule

`default_nettype wire

### design/cdo_month_len.sv
// cdo_month_len: days in a month, given the month and a leap-year flag
// depends on cdo_pkg
`default_nettype none

module cdo_month_len (
    input  logic [cdo_pkg::MONTH_W-1:0] month,
    input  logic                        leap,
    output logic [cdo_pkg::MLEN_W-1:0]  len
);

    always_comb
    begin
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            cdo_pkg::MONTH_FEB:                          len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
    end

endmodule

`default_nettype wire

### design/calendar_date_offset_top.sv
// calendar_date_offset_top: gregorian date plus or minus a day count
// depends on cdo_pkg, cdo_if, cdo_alu, cdo_month_len
//
//  channel | dir | payload                                          | beat
//  --------+-----+--------------------------------------------------+---------------------
//  req     | in  | req_type, in_year, in_month, in_day, day_count   | valid & ready
//  rsp     | out | out_year, out_month, out_day, status             | valid & ready
//
// one beat is worked out by the single add/subtract unit: one century per cycle while
// splitting the year, then one month per cycle while walking
// an invalid month or out-of-range year goes straight to the result, skipping split and walk
// rsp holds its beat until taken; req is not ready from acceptance until then
// rst_n clears the sequencer asynchronously; no clearing pass is needed
`default_nettype none

module calendar_date_offset_top (
    input  logic          clk,
    input  logic          rst_n,
    cdo_req_if.sink       req,
    cdo_rsp_if.source     rsp
);

    localparam int ACC_W   = cdo_pkg::ACC_W;
    localparam int YEAR_W  = cdo_pkg::YEAR_W;
    localparam int MONTH_W = cdo_pkg::MONTH_W;
    localparam int YLIM_W  = cdo_pkg::YLIM_W;

    // sequencer state
    cdo_pkg::cdo_state_t state_reg, state_next;

    // working registers
    logic                       op_reg,     op_next;
    logic [YEAR_W-1:0]          year_reg,   year_next;
    logic [MONTH_W-1:0]         month_reg,  month_next;
    logic signed [ACC_W-1:0]    day_reg,    day_next;
    logic [YEAR_W-1:0]          rem_reg,    rem_next;   // year mod 100 once split
    logic [1:0]                 cent_reg,   cent_next;  // century mod 4
    cdo_pkg::cdo_status_t       status_reg, status_next;

    // shared unit
    logic signed [ACC_W-1:0]    alu_a, alu_b, alu_res;
    logic                       alu_sub;

    // month length lookup
    logic [MONTH_W-1:0]         len_month;
    logic [cdo_pkg::MLEN_W-1:0] len_days;
    logic                       leap;

    logic                       req_beat;
    logic [cdo_pkg::CNT_W-1:0]  count;
    logic                       bad_month;
    logic                       year_high;
    logic                       res_pos;
    logic                       walk_more;
    logic                       wrap;
    logic                       at_year_end;
    logic                       walk_fail;

    assign req_beat  = req.valid && req.ready;
    assign count     = req.data.day_count & cdo_pkg::CNT_MASK;
    assign bad_month = (req.data.in_month == 4'd0) || (req.data.in_month > cdo_pkg::MONTH_DEC);
    assign year_high = YLIM_W'(req.data.in_year) > cdo_pkg::YEAR_MAX;

    // leap rule from year mod 100 and century mod 4
    assign leap = (rem_reg[1:0] == 2'd0) && ((rem_reg != '0) || (cent_reg == 2'd0));

    // subtracting needs the previous month; december is always 31 days
    always_comb
    begin
        if (!op_reg)
        begin
            len_month = month_reg;
        end
        else if (month_reg == cdo_pkg::MONTH_JAN)
        begin
            len_month = cdo_pkg::MONTH_DEC;
        end
        else
        begin
            len_month = month_reg - 4'd1;
        end
    end

    cdo_month_len u_month_len (
        .month (len_month),
        .leap  (leap),
        .len   (len_days)
    );

    // operand selection for the shared unit
    always_comb
    begin
        unique case (state_reg)
            cdo_pkg::ST_IDLE:
            begin
                alu_a   = ACC_W'(req.data.in_day);
                alu_b   = ACC_W'(count);
                alu_sub = req.data.req_type;
            end
            cdo_pkg::ST_SPLIT:
            begin
                alu_a   = ACC_W'(rem_reg);
                alu_b   = ACC_W'(cdo_pkg::YEARS_PER_CENTURY);
                alu_sub = 1'b1;
            end
            cdo_pkg::ST_WALK:
            begin
                alu_a   = day_reg;
                alu_b   = ACC_W'(len_days);
                alu_sub = !op_reg;
            end
            default:
            begin
                alu_a   = day_reg;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    cdo_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .res (alu_res)
    );

    // walk decisions: adding moves on while day exceeds the month length,
    // subtracting borrows while day is below one
    assign res_pos     = !alu_res[ACC_W-1] && (alu_res != '0);
    assign walk_more   = op_reg ? (day_reg[ACC_W-1] || (day_reg == '0)) : res_pos;
    assign wrap        = op_reg ? (month_reg == cdo_pkg::MONTH_JAN)
                                : (month_reg == cdo_pkg::MONTH_DEC);
    assign at_year_end = op_reg ? (year_reg == '0)
                                : (YLIM_W'(year_reg) == cdo_pkg::YEAR_MAX);
    assign walk_fail   = walk_more && wrap && at_year_end;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cdo_pkg::ST_IDLE:
            begin
                if (req_beat)
                begin
                    state_next = (bad_month || year_high) ? cdo_pkg::ST_DONE
                                                          : cdo_pkg::ST_SPLIT;
                end
            end
            cdo_pkg::ST_SPLIT:
            begin
                if (alu_res[ACC_W-1])
                begin
                    state_next = cdo_pkg::ST_WALK;
                end
            end
            cdo_pkg::ST_WALK:
            begin
                if (!walk_more || walk_fail)
                begin
                    state_next = cdo_pkg::ST_DONE;
                end
            end
            cdo_pkg::ST_DONE:
            begin
                if (rsp.ready)
                begin
                    state_next = cdo_pkg::ST_IDLE;
                end
            end
            default: state_next = cdo_pkg::ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb
    begin
        op_next     = op_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        rem_next    = rem_reg;
        cent_next   = cent_reg;
        status_next = status_reg;
        unique case (state_reg)
            cdo_pkg::ST_IDLE:
            begin
                if (req_beat)
                begin
                    op_next    = req.data.req_type;
                    year_next  = req.data.in_year;
                    month_next = req.data.in_month;
                    day_next   = alu_res;
                    rem_next   = req.data.in_year;
                    cent_next  = 2'd0;
                    if (bad_month)
                    begin
                        status_next = cdo_pkg::STATUS_BAD_MONTH;
                    end
                    else if (year_high)
                    begin
                        status_next = cdo_pkg::STATUS_RANGE;
                    end
                    else
                    begin
                        status_next = cdo_pkg::STATUS_OK;
                    end
                end
            end
            cdo_pkg::ST_SPLIT:
            begin
                // strip one century per cycle
                if (!alu_res[ACC_W-1])
                begin
                    rem_next  = alu_res[YEAR_W-1:0];
                    cent_next = cent_reg + 2'd1;
                end
            end
            cdo_pkg::ST_WALK:
            begin
                if (walk_fail)
                begin
                    status_next = cdo_pkg::STATUS_RANGE;
                end
                else if (walk_more)
                begin
                    day_next = alu_res;
                    if (!op_reg)
                    begin
                        month_next = wrap ? cdo_pkg::MONTH_JAN : month_reg + 4'd1;
                        if (wrap)
                        begin
                            year_next = year_reg + YEAR_W'(1);
                            if (rem_reg[6:0] == cdo_pkg::LAST_YEAR_OF_CENTURY)
                            begin
                                rem_next  = '0;
                                cent_next = cent_reg + 2'd1;
                            end
                            else
                            begin
                                rem_next = rem_reg + YEAR_W'(1);
                            end
                        end
                    end
                    else
                    begin
                        month_next = wrap ? cdo_pkg::MONTH_DEC : month_reg - 4'd1;
                        if (wrap)
                        begin
                            year_next = year_reg - YEAR_W'(1);
                            if (rem_reg == '0)
                            begin
                                rem_next  = YEAR_W'(cdo_pkg::LAST_YEAR_OF_CENTURY);
                                cent_next = cent_reg - 2'd1;
                            end
                            else
                            begin
                                rem_next = rem_reg - YEAR_W'(1);
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cdo_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        year_reg   <= year_next;
        month_reg  <= month_next;
        day_reg    <= day_next;
        rem_reg    <= rem_next;
        cent_reg   <= cent_next;
        status_reg <= status_next;
    end

    // handshake and result beat; failed requests report a zero date
    always_comb
    begin
        req.ready = (state_reg == cdo_pkg::ST_IDLE);
        rsp.valid = (state_reg == cdo_pkg::ST_DONE);
        rsp.data.status = status_reg;
        if (status_reg == cdo_pkg::STATUS_OK)
        begin
            rsp.data.out_year  = year_reg;
            rsp.data.out_month = month_reg;
            rsp.data.out_day   = day_reg[cdo_pkg::DAY_W-1:0];
        end
        else
        begin
            rsp.data.out_year  = '0;
            rsp.data.out_month = '0;
            rsp.data.out_day   = '0;
        end
    end

endmodule

`default_nettype wire

### bench/tb_top.sv
// tb_top: self-checking bench for calendar_date_offset_top, the date plus/minus day count block
// depends on cdo_pkg, cdo_if and the block's rtl; holds its own date predictor
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int YEAR_W     = cdo_pkg::YEAR_W;
    localparam int MONTH_W    = cdo_pkg::MONTH_W;
    localparam int DAY_W      = cdo_pkg::DAY_W;
    localparam int CNT_W      = cdo_pkg::CNT_W;
    localparam int YEAR_LIMIT = cdo_pkg::YEAR_LIMIT;

    // request selector codes
    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SUB = 1'b1;

    localparam int MAX_REPORTS  = 10;
    // nothing is in flight once the queue is empty; a short quiet window
    // catches any stray beat
    localparam int QUIET_CYCLES = 64;

    logic clk;
    logic rst_n;

    cdo_req_if req_ch ();
    cdo_rsp_if rsp_ch ();

    calendar_date_offset_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // dates the block still owes us, oldest first
    cdo_pkg::cdo_rsp_t expected_dates[$];

    // idling knobs, in percent per cycle
    int send_idle_pct   = 0;
    int ready_stall_pct = 0;
    int fail_count      = 0;

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: the slowest legal run (every beat on its longest walk
    // plus idling) stays well below this
    initial
    begin
        #50_000_000;
        $display("calendar_date_offset_top test failed");
        $finish;
    end

    // gregorian leap rule: every 4th year, but not centuries unless divisible by 400
    function automatic bit is_leap_year(int y);
        if (y % 4 != 0)
            return 1'b0;
        if (y % 100 != 0)
            return 1'b1;
        return (y % 400) == 0;
    endfunction

    function automatic int days_in_month(int y, int m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return is_leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // shifted date for one request beat
    function automatic cdo_pkg::cdo_rsp_t predict_shifted_date(cdo_pkg::cdo_req_t item);
        int                   year;
        int                   month;
        int                   day;
        int                   count;
        cdo_pkg::cdo_status_t st;
        cdo_pkg::cdo_rsp_t    res;
        year  = int'(item.in_year);
        month = int'(item.in_month);
        day   = int'(item.in_day);
        count = int'(item.day_count & cdo_pkg::CNT_MASK);
        st    = cdo_pkg::STATUS_OK;
        if (month < int'(cdo_pkg::MONTH_JAN) || month > int'(cdo_pkg::MONTH_DEC))
            st = cdo_pkg::STATUS_BAD_MONTH;
        else if (year > YEAR_LIMIT)
            st = cdo_pkg::STATUS_RANGE;
        else if (item.req_type == OP_ADD)
        begin
            // carry whole months forward until the day fits
            day += count;
            while (day > days_in_month(year, month))
            begin
                day -= days_in_month(year, month);
                month++;
                if (month > int'(cdo_pkg::MONTH_DEC))
                begin
                    month = int'(cdo_pkg::MONTH_JAN);
                    year++;
                    if (year > YEAR_LIMIT)
                    begin
                        st = cdo_pkg::STATUS_RANGE;
                        break;
                    end
                end
            end
        end
        else
        begin
            // borrow whole months backward until the day is positive
            day -= count;
            while (day < 1)
            begin
                month--;
                if (month < int'(cdo_pkg::MONTH_JAN))
                begin
                    month = int'(cdo_pkg::MONTH_DEC);
                    year--;
                    if (year < 0)
                    begin
                        st = cdo_pkg::STATUS_RANGE;
                        break;
                    end
                end
                day += days_in_month(year, month);
            end
        end
        res = '0;
        res.status = st;
        if (st == cdo_pkg::STATUS_OK)
        begin
            res.out_year  = YEAR_W'(year);
            res.out_month = MONTH_W'(month);
            res.out_day   = DAY_W'(day);
        end
        return res;
    endfunction

    task automatic report_failure(string what, cdo_pkg::cdo_rsp_t want, cdo_pkg::cdo_rsp_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t %s: expected y=%0d m=%0d d=%0d st=%0d, got y=%0d m=%0d d=%0d st=%0d",
                     $time, what, want.out_year, want.out_month, want.out_day, want.status,
                     got.out_year, got.out_month, got.out_day, got.status);
    endtask

    // receiver side: ready is redrawn every falling edge
    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(0, 99) >= ready_stall_pct);

    // result checker: compares each rsp beat with the oldest predicted date
    always @(posedge clk)
    begin
        cdo_pkg::cdo_rsp_t got;
        cdo_pkg::cdo_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.data;
            if (expected_dates.size() == 0)
                report_failure("result beat with none expected", '0, got);
            else
            begin
                want = expected_dates.pop_front();
                if (got.out_year !== want.out_year || got.out_month !== want.out_month ||
                    got.out_day !== want.out_day || got.status !== want.status)
                    report_failure("date mismatch", want, got);
            end
        end
    end

    // sender: optional idle gap, then hold the beat until ready; valid stays
    // high afterwards so back-to-back beats never drop it
    task automatic send_item(cdo_pkg::cdo_req_t item);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        expected_dates.push_back(predict_shifted_date(item));
    endtask

    task automatic send_date(logic op, int y, int m, int d, int cnt);
        cdo_pkg::cdo_req_t item;
        item.req_type  = op;
        item.in_year   = YEAR_W'(y);
        item.in_month  = MONTH_W'(m);
        item.in_day    = DAY_W'(d);
        item.day_count = CNT_W'(cnt);
        send_item(item);
    endtask

    // invalid month wins over everything, then the year range check
    task automatic test_status_codes();
        send_date(OP_ADD, 2020, 0, 10, 5);
        send_date(OP_SUB, 2020, 13, 10, 5);
        send_date(OP_ADD, 16383, 15, 31, 65535);
        send_date(OP_ADD, 10000, 6, 15, 0);
        send_date(OP_SUB, 16383, 12, 1, 1);
        send_date(OP_ADD, 9999, 12, 31, 0);
    endtask

    // december into january and back, plus both ends of the year range
    task automatic test_month_and_year_rollover();
        send_date(OP_ADD, 1999, 12, 31, 1);
        send_date(OP_SUB, 2001, 1, 1, 1);
        send_date(OP_ADD, 9999, 12, 31, 1);
        send_date(OP_SUB, 0, 1, 1, 1);
        send_date(OP_SUB, 0, 1, 15, 14);
    endtask

    // 400-year leap, skipped century leap, ordinary leap
    task automatic test_leap_years();
        send_date(OP_ADD, 2000, 2, 28, 1);
        send_date(OP_ADD, 1900, 2, 28, 1);
        send_date(OP_SUB, 2100, 3, 1, 1);
        send_date(OP_SUB, 2004, 3, 0, 0);
        send_date(OP_ADD, 2024, 2, 29, 365);
    endtask

    // day zero stays zero on add; oversized day carries on add, stays on subtract
    task automatic test_day_normalization();
        send_date(OP_ADD, 2023, 1, 0, 0);
        send_date(OP_ADD, 2023, 2, 31, 0);
        send_date(OP_SUB, 2023, 2, 31, 0);
        send_date(OP_SUB, 2023, 4, 31, 30);
    endtask

    // full-scale counts: the longest walks in each direction, with and without overflow
    task automatic test_count_extremes();
        send_date(OP_ADD, 0, 1, 1, 65535);
        send_date(OP_SUB, 9999, 12, 31, 65535);
        send_date(OP_SUB, 100, 3, 1, 65535);
        send_date(OP_ADD, 9900, 1, 1, 65535);
    endtask

    // random dates: mostly valid months and in-range years, with some bad
    // months, out-of-range years and years near both ends; counts mostly
    // short to keep the walk short, a quarter over the full 16 bits
    task automatic test_random_traffic(int n, int gap_pct, int stall_pct);
        cdo_pkg::cdo_req_t item;
        int                k;
        send_idle_pct   = gap_pct;
        ready_stall_pct = stall_pct;
        repeat (n)
        begin
            item.req_type = $urandom_range(0, 1) ? OP_SUB : OP_ADD;
            item.in_day   = DAY_W'($urandom_range(0, 31));
            if ($urandom_range(0, 19) == 0)
            begin
                k = $urandom_range(0, 3);
                item.in_month = (k == 0) ? MONTH_W'(0)
                                         : MONTH_W'(int'(cdo_pkg::MONTH_DEC) + k);
            end
            else
                item.in_month = MONTH_W'($urandom_range(1, 12));
            case ($urandom_range(0, 19))
                0:       item.in_year = YEAR_W'($urandom_range(YEAR_LIMIT + 1, 16383));
                1:       item.in_year = YEAR_W'($urandom_range(0, 3));
                2:       item.in_year = YEAR_W'($urandom_range(YEAR_LIMIT - 3, YEAR_LIMIT));
                default: item.in_year = YEAR_W'($urandom_range(0, YEAR_LIMIT));
            endcase
            if ($urandom_range(0, 3) == 0)
                item.day_count = CNT_W'($urandom_range(0, 65535));
            else
                item.day_count = CNT_W'($urandom_range(0, 1500));
            send_item(item);
        end
    endtask

    // main sequence: reset, directed cases with no idling, then random
    // traffic under each idling mix
    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        rst_n        = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_status_codes();
        test_month_and_year_rollover();
        test_leap_years();
        test_day_normalization();
        test_count_extremes();

        test_random_traffic(64, 0, 0);
        test_random_traffic(60, 83, 0);
        test_random_traffic(60, 0, 83);
        test_random_traffic(62, 36, 36);

        // last beat was taken at the previous rising edge
        @(negedge clk);
        req_ch.valid <= 1'b0;

        while (expected_dates.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_dates.size() == 0)
            $display("calendar_date_offset_top test passed");
        else
            $display("calendar_date_offset_top test failed");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
design/cdo_pkg.sv
design/cdo_if.sv
design/cdo_alu.sv
design/cdo_month_len.sv
design/calendar_date_offset_top.sv
bench/tb_top.sv
